FILE: rtl/core/grouped_modulo_round_robin_arbiter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grouped round-robin arbiter
// Used by the arbiter unit, which checks its own sequencing.
// ----------------------------------------------------------------------------
`ifndef GROUPED_MODULO_ROUND_ROBIN_ARBITER_UNIT_DEFINES_SVH
`define GROUPED_MODULO_ROUND_ROBIN_ARBITER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks that an expression holds at every clock edge outside reset.
`define GMRR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define GMRR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define GMRR_ASSERT_ALWAYS(label, expr, msg)
`define GMRR_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gmrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmrr_pkg
// Widths, register indexes and handshake structs of the grouped arbiter.
// ----------------------------------------------------------------------------
package gmrr_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SIDE_W    = 2;
  localparam int CTR_W     = 32;
  // Wide enough for a member count of up to MAX_SLOTS.
  localparam int CNT_W     = 5;
  // Dividend bits retired per cycle by the remainder unit.
  localparam int DIGIT_W   = 4;
  localparam int REM_STEPS = CTR_W / DIGIT_W;
  localparam int STEP_W    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATE_RW_BUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_SIDE_CODE   = 1'd1;

  typedef struct packed {
    logic             start;
    logic [CTR_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] remainder;
  } rem_rsp_t;

endpackage

FILE: rtl/core/gmrr_group_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmrr_group_map
// Assigns each eligible slot to its arbitration group.
// ----------------------------------------------------------------------------
module gmrr_group_map #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_SIDES = 4,
  parameter int GRP_W     = 3
) (
  input  logic [NUM_SLOTS-1:0]                      eligible,
  input  logic [NUM_SLOTS-1:0]                      direction,
  input  logic [NUM_SLOTS-1:0][gmrr_pkg::SIDE_W-1:0] sides,
  input  logic                                      separate_rw_bus,
  input  logic [gmrr_pkg::SIDE_W-1:0]               dma_side_code,
  output logic [NUM_SLOTS-1:0]                      slot_ok,
  output logic [NUM_SLOTS-1:0][GRP_W-1:0]           slot_grp
);

  always_comb begin
    logic side_valid;
    logic is_in;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      side_valid  = ({1'b0, sides[s]} < (gmrr_pkg::SIDE_W + 1)'(NUM_SIDES));
      // With a shared bus, DMA-side inputs fall into the output group.
      is_in       = direction[s] && !(!separate_rw_bus && (sides[s] == dma_side_code));
      slot_ok[s]  = eligible[s] && side_valid;
      slot_grp[s] = is_in ? (GRP_W'(sides[s]) + GRP_W'(NUM_SIDES)) : GRP_W'(sides[s]);
    end
  end

endmodule

FILE: rtl/core/gmrr_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmrr_rem_unit
// Restoring remainder unit: counter mod member count, four bits a cycle.
// ----------------------------------------------------------------------------
module gmrr_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  gmrr_pkg::rem_req_t req,
  output gmrr_pkg::rem_rsp_t rsp
);

  logic                                busy;
  logic [gmrr_pkg::STEP_W-1:0]         step;
  logic [gmrr_pkg::CTR_W-1:0]          shift;
  logic [gmrr_pkg::CNT_W-1:0]          divisor;
  logic [gmrr_pkg::CNT_W-1:0]          rem;
  logic [gmrr_pkg::CNT_W-1:0]          rem_next;
  logic                                done;

  always_comb begin
    logic [gmrr_pkg::CNT_W:0] trial;
    rem_next = rem;
    for (int k = 0; k < gmrr_pkg::DIGIT_W; k++) begin
      trial = {rem_next, shift[gmrr_pkg::CTR_W-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_next = trial[gmrr_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        shift   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shift <= shift << gmrr_pkg::DIGIT_W;
        step  <= step + 1'b1;
        if (step == gmrr_pkg::STEP_W'(gmrr_pkg::REM_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

FILE: rtl/core/grouped_modulo_round_robin_arbiter_unit.sv
`timescale 1ns / 1ps
// Each accepted word is worked through all groups (2 * NUM_SIDES) in order before
// its grant word is sent; an empty group is passed over in the scan state.
// A non-empty group is scanned, divided in the shared remainder unit (4 bits a cycle)
// and its pick is then folded into the grant before the scan moves to the next group.
// Flow: words are taken only in idle, one at a time; the next word is taken while a grant waits.
// Reset: synchronous rst clears the group counters, both registers and all valids.
// ----------------------------------------------------------------------------
// grouped_modulo_round_robin_arbiter_unit
// Per-group round-robin arbiter sequencing one shared remainder unit.
// ----------------------------------------------------------------------------
`include "grouped_modulo_round_robin_arbiter_unit_defines.svh"

module grouped_modulo_round_robin_arbiter_unit #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_SIDES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // eligible_mask [15:0], direction_mask [31:16], side_codes [63:32]
  input  logic [63:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // grant_mask [15:0]
  output logic [15:0]                         m_tdata,
  input  logic                                cfg_we,
  input  logic [gmrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmrr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_GROUPS = 2 * NUM_SIDES;
  localparam int GRP_W      = $clog2(NUM_GROUPS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                          state;
  logic [GRP_W-1:0]                    grp;
  logic                                separate_rw_bus;
  logic [gmrr_pkg::SIDE_W-1:0]         dma_side_code;
  logic [gmrr_pkg::CTR_W-1:0]          counters [NUM_GROUPS];
  logic [NUM_SLOTS-1:0]                slot_ok;
  logic [NUM_SLOTS-1:0][GRP_W-1:0]     slot_grp;
  logic [NUM_SLOTS-1:0]                map_ok;
  logic [NUM_SLOTS-1:0][GRP_W-1:0]     map_grp;
  logic [NUM_SLOTS-1:0]                grant;
  logic [NUM_SLOTS-1:0]                member;
  logic [NUM_SLOTS-1:0]                pick_mask;
  logic [gmrr_pkg::CNT_W-1:0]          grp_count;
  logic                                last_grp;
  logic                                accept;
  gmrr_pkg::rem_req_t                  req;
  gmrr_pkg::rem_rsp_t                  rsp;

  function automatic logic [gmrr_pkg::CNT_W-1:0] popcnt(input logic [NUM_SLOTS-1:0] v);
    logic [gmrr_pkg::CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      n = n + gmrr_pkg::CNT_W'(v[i]);
    end
    return n;
  endfunction

  gmrr_group_map #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_SIDES (NUM_SIDES),
    .GRP_W     (GRP_W)
  ) u_group_map (
    .eligible        (s_tdata[NUM_SLOTS-1:0]),
    .direction       (s_tdata[16 +: NUM_SLOTS]),
    .sides           (s_tdata[32 +: (gmrr_pkg::SIDE_W * NUM_SLOTS)]),
    .separate_rw_bus (separate_rw_bus),
    .dma_side_code   (dma_side_code),
    .slot_ok         (map_ok),
    .slot_grp        (map_grp)
  );

  gmrr_rem_unit u_rem_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign last_grp = (grp == GRP_W'(NUM_GROUPS - 1));

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      member[s] = slot_ok[s] && (slot_grp[s] == grp);
    end
  end

  assign grp_count = popcnt(member);

  // The granted member is the one with exactly "remainder" members below it.
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      pick_mask[s] = member[s] &&
                     (popcnt(member & ((NUM_SLOTS'(1) << s) - 1'b1)) == rsp.remainder);
    end
  end

  assign req.start    = (state == ST_SCAN) && (grp_count != '0);
  assign req.dividend = counters[grp];
  assign req.divisor  = grp_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      separate_rw_bus <= 1'b0;
      dma_side_code   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gmrr_pkg::CFG_SEPARATE_RW_BUS: separate_rw_bus <= cfg_data[0];
        gmrr_pkg::CFG_DMA_SIDE_CODE:   dma_side_code   <= cfg_data[gmrr_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      grp      <= '0;
      m_tvalid <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        counters[g] <= '0;
      end
    end else begin
      // In drain the valid is set again below when the word moves on.
      if (m_tvalid && m_tready && (state != ST_DRAIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot_ok  <= map_ok;
            slot_grp <= map_grp;
            grant    <= '0;
            grp      <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (grp_count != '0) begin
            state <= ST_WAIT;
          end else if (last_grp) begin
            state <= ST_DRAIN;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        ST_WAIT: begin
          if (rsp.done) begin
            grant         <= grant | pick_mask;
            counters[grp] <= counters[grp] + 1'b1;
            if (last_grp) begin
              state <= ST_DRAIN;
            end else begin
              grp   <= grp + 1'b1;
              state <= ST_SCAN;
            end
          end
        end
        ST_DRAIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 16'(grant);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GMRR_ASSERT_IMPLY(a_done_only_in_wait, rsp.done, state == ST_WAIT, "done outside wait")
  `GMRR_ASSERT_IMPLY(a_rem_below_count, rsp.done, rsp.remainder < grp_count, "remainder too big")
  `GMRR_ASSERT_IMPLY(a_single_pick, rsp.done, $onehot(pick_mask), "group grant not one-hot")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grouped round-robin arbiter. A directed table
// covers the extremes and the DMA bus merge, then random rounds run in
// several register settings. Every grant word is checked against a local
// model of the per-group counters, or against a grant typed in the table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_SLOTS   = 16;
  localparam int NUM_SIDES   = 4;
  localparam int NUM_GROUPS  = 2 * NUM_SIDES;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 110;
  localparam int NUM_PHASES  = 5;
  localparam int DRAIN_WAIT  = 100;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [gmrr_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [gmrr_pkg::CFG_DATA_W-1:0] reg_val;
    logic [15:0]                     elig;
    logic [15:0]                     dir;
    logic [31:0]                     sides;
    bit                              typed;
    logic [15:0]                     grant;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [63:0]                     s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [15:0]                     m_tdata;
  logic                            cfg_we = 1'b0;
  logic [gmrr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gmrr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the arbiter state and registers.
  logic [31:0]           grp_ctr [NUM_GROUPS];
  logic                  sep_rw_bus = 1'b0;
  logic [1:0]            dma_side = 2'd0;

  logic [15:0]           pending_grants [$];
  stim_row_t             directed_rows [$];
  int                    mismatch_count = 0;
  int                    burst_left = 0;
  bit                    hold_off_req = 1'b0;
  logic [15:0]           prev_elig = '0;
  logic [15:0]           prev_dir = '0;
  logic [31:0]           prev_sides = '0;
  logic [15:0]           got_want;

  grouped_modulo_round_robin_arbiter_unit #(
    .NUM_SLOTS(NUM_SLOTS),
    .NUM_SIDES(NUM_SIDES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Works out one round: groups the eligible slots, grants the member at
  // counter mod member count in scan order, and advances the used counters.
  function automatic logic [15:0] predict_grant(input logic [15:0] elig,
                                                input logic [15:0] dir,
                                                input logic [31:0] sides);
    int          slot_grp [NUM_SLOTS];
    int unsigned members [NUM_GROUPS];
    logic [31:0] pick;
    int unsigned seen;
    logic [1:0]  side;
    logic        is_in;
    logic [15:0] grant;
    grant = '0;
    for (int g = 0; g < NUM_GROUPS; g++) members[g] = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      side = sides[2*s +: 2];
      is_in = dir[s];
      slot_grp[s] = -1;
      if (elig[s] && side < NUM_SIDES) begin
        if (!sep_rw_bus && side == dma_side) is_in = 1'b0;
        slot_grp[s] = int'(is_in) * NUM_SIDES + int'(side);
        members[slot_grp[s]]++;
      end
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (members[g] != 0) begin
        pick = grp_ctr[g] % members[g];
        seen = 0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_grp[s] == g) begin
            if (seen == pick) begin
              grant[s] = 1'b1;
              break;
            end
            seen++;
          end
        end
        grp_ctr[g] = grp_ctr[g] + 32'd1;
      end
    end
    return grant;
  endfunction

  task automatic add_word(input logic [15:0] elig, input logic [15:0] dir,
                          input logic [31:0] sides, input bit typed,
                          input logic [15:0] grant);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.elig = elig;
    row.dir = dir;
    row.sides = sides;
    row.typed = typed;
    row.grant = grant;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_reg(input logic [gmrr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [gmrr_pkg::CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.elig = '0;
    row.dir = '0;
    row.sides = '0;
    row.typed = 1'b0;
    row.grant = '0;
    directed_rows = {directed_rows, row};
  endtask

  // Called and returns at a falling edge.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [gmrr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gmrr_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    if (idx == gmrr_pkg::CFG_SEPARATE_RW_BUS) begin
      sep_rw_bus = val[0];
    end else begin
      dma_side = val;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one word in the current burst; a new burst starts after a gap.
  task automatic offer_word(input logic [15:0] elig, input logic [15:0] dir,
                            input logic [31:0] sides, input bit typed,
                            input logic [15:0] grant);
    logic [15:0] want;
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
      burst_left = $urandom_range(40, 1);
    end
    s_tdata = {sides, dir, elig};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_grant(elig, dir, sides);
    if (typed) want = grant;
    pending_grants = {pending_grants, want};
    burst_left--;
    @(negedge clk);
  endtask

  task automatic make_round(output logic [15:0] elig, output logic [15:0] dir,
                            output logic [31:0] sides);
    logic [1:0] sd;
    elig = 16'($urandom());
    dir = 16'($urandom());
    sides = $urandom();
    case ($urandom_range(9, 0))
      0, 1: begin
        // Same round again walks the counters through their groups.
        elig = prev_elig;
        dir = prev_dir;
        sides = prev_sides;
      end
      5, 6: elig = 16'hFFFF;
      7: elig = (16'h1 << $urandom_range(15, 0)) | (16'h1 << $urandom_range(15, 0));
      8: begin
        sd = 2'($urandom_range(3, 0));
        sides = {16{sd}};
      end
      9: dir = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    prev_elig = elig;
    prev_dir = dir;
    prev_sides = sides;
  endtask

  // Grant side stalls on its own pattern, with one long hold-off on request.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case ((cyc / 97) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(3, 0) != 0);
        default: m_tready <= 1'($urandom_range(1, 0));
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("grant word 0x%04h with none expected", m_tdata));
      end else begin
        got_want = pending_grants.pop_front();
        if (m_tdata !== got_want) begin
          report_mismatch($sformatf("grant_mask 0x%04h, expected 0x%04h",
                                    m_tdata, got_want));
        end
      end
    end
  end

  initial begin
    logic [15:0] elig;
    logic [15:0] dir;
    logic [31:0] sides;
    stim_row_t   row;
    for (int g = 0; g < NUM_GROUPS; g++) grp_ctr[g] = '0;

    // Rows with a typed grant start from the counters as reset leaves them.
    add_word(16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000);
    add_word(16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, 16'h0001);
    add_word(16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, 16'h0002);
    // Inputs on the DMA side share the output group while the bus is shared.
    add_word(16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 16'h0004);
    add_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0001);
    add_word(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1, 16'h0001);
    add_word(16'hFFFF, 16'hAAAA, 32'h0000_0000, 1'b0, '0);
    add_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd1);
    add_word(16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b1, 16'h0001);
    add_word(16'hFFFF, 16'h5555, 32'hE4E4_E4E4, 1'b0, '0);
    add_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd3);
    add_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd0);
    add_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
    // A lone member is always granted.
    add_word(16'h8000, 16'h8000, 32'hC000_0000, 1'b1, 16'h8000);
    add_word(16'h0001, 16'h0001, 32'h0000_0001, 1'b1, 16'h0001);
    add_word(16'h5A5A, 16'h3C3C, 32'h1234_5678, 1'b0, '0);
    add_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd1);
    add_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd1);
    add_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd0);
    add_word(16'hFFFF, 16'h00FF, 32'h5555_5555, 1'b0, '0);
    add_word(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000);
    add_word(16'h0F0F, 16'hFFFF, 32'hAAAA_AAAA, 1'b0, '0);
    add_word(16'hFFFF, 16'h0000, 32'h1B1B_1B1B, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_word(row.elig, row.dir, row.sides, row.typed, row.grant);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd0);
          write_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd0);
        end
        1: begin
          write_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd1);
          write_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd3);
        end
        2: begin
          write_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd0);
          write_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd3);
        end
        3: begin
          write_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd1);
          write_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'd0);
        end
        default: begin
          write_reg(gmrr_pkg::CFG_SEPARATE_RW_BUS, 2'd0);
          write_reg(gmrr_pkg::CFG_DMA_SIDE_CODE, 2'($urandom_range(2, 1)));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // The grant side holds off once while words keep coming in.
        if (ph == 0 && n == 30) hold_off_req = 1'b1;
        if (ph == 2 && n == 50) wait_drained();
        make_round(elig, dir, sides);
        offer_word(elig, dir, sides, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
